/* rtl/mprc_pkg.sv */
// Shared types, constants and helper functions of the masked pixel converter.
package mprc_pkg;

	localparam int unsigned MAX_DIM = 4096;
	localparam int unsigned DIM_W = 13;
	localparam int unsigned CNT_W = 12;
	localparam int unsigned IDX_W = 24;
	localparam int unsigned PIX_W = 32;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned NUM_CHAN = 4;
	localparam int unsigned SHAMT_W = 5;
	localparam int unsigned CFG_IDX_W = 3;

	localparam int unsigned CH_RED = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE = 2;
	localparam int unsigned CH_ALPHA = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RED_MASK = 3'd0,
		REG_GREEN_MASK = 3'd1,
		REG_BLUE_MASK = 3'd2,
		REG_ALPHA_MASK = 3'd3,
		REG_IMAGE_WIDTH = 3'd4,
		REG_IMAGE_HEIGHT = 3'd5,
		REG_FLIP_VERTICAL = 3'd6,
		REG_FLIP_HORIZONTAL = 3'd7
	} reg_idx_t;

	// How a channel's masked bits move to put the mask's top bit on bit 7.
	typedef struct packed {
		logic shift_right;
		logic [SHAMT_W-1:0] amount;
	} chan_shift_t;

	function automatic chan_shift_t calc_shift(input logic [PIX_W-1:0] mask);
		logic [SHAMT_W-1:0] top;
		chan_shift_t sh;
		top = '0;
		for (int i = 0; i < PIX_W; i++) begin
			if (mask[i]) begin
				top = SHAMT_W'(i);
			end
		end
		if (top >= SHAMT_W'(CHAN_W - 1)) begin
			sh.shift_right = 1'b1;
			sh.amount = top - SHAMT_W'(CHAN_W - 1);
		end else begin
			sh.shift_right = 1'b0;
			sh.amount = SHAMT_W'(CHAN_W - 1) - top;
		end
		return sh;
	endfunction

	// Zero acts as one, anything above the maximum acts as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		if (d == '0) begin
			r = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = d;
		end
		return r;
	endfunction

endpackage

/* rtl/mprc_in_if.sv */
// Input channel interface: one source pixel per transfer.
interface mprc_in_if;
	logic valid;
	logic ready;
	logic [31:0] source_pixel;

	modport source(output valid, output source_pixel, input ready);
	modport sink(input valid, input source_pixel, output ready);
endinterface

/* rtl/mprc_out_if.sv */
// Output channel interface: one converted pixel with its destination index per transfer.
interface mprc_out_if;
	logic valid;
	logic ready;
	logic [31:0] rgba_word;
	logic [23:0] dest_index;
	logic last_pixel;

	modport source(output valid, output rgba_word, output dest_index, output last_pixel,
		input ready);
	modport sink(input valid, input rgba_word, input dest_index, input last_pixel,
		output ready);
endinterface

/* rtl/mprc_chan_place.sv */
// Extracts one channel's masked bits and aligns them into an 8-bit channel value.
module mprc_chan_place (
	input logic [mprc_pkg::PIX_W-1:0] pixel,
	input logic [mprc_pkg::PIX_W-1:0] mask,
	input mprc_pkg::chan_shift_t shift,
	output logic [mprc_pkg::CHAN_W-1:0] value
);
	import mprc_pkg::*;

	logic [PIX_W-1:0] masked;
	logic [PIX_W-1:0] moved;

	assign masked = pixel & mask;

	always_comb begin
		if (shift.shift_right) begin
			moved = masked >> shift.amount;
		end else begin
			moved = masked << shift.amount;
		end
	end

	assign value = moved[CHAN_W-1:0];

endmodule

/* rtl/masked_pixel_to_rgba_converter_core.sv */
// Top level of the masked pixel to RGBA8888 converter.
// This block converts one source pixel per clock into an RGBA8888 word (red in bits 7:0,
// green 15:8, blue 23:16, alpha 31:24) and tags it with its destination pixel index and a
// last-pixel flag. Each channel takes the source bits under its mask and moves them so that
// the mask's highest bit lands on bit 7 of the channel byte; a zero mask gives 0, and a zero
// alpha mask gives an opaque 0xFF. The shift for each channel is worked out when its mask is
// written, so the pixel path is only an AND and one barrel shift. Column and row counters
// follow the image in source order and yield row times width plus column, with optional
// horizontal and vertical flips; width and height of 0 act as 1 and values above 4096 act
// as 4096. While the sink is ready, the block sustains one transfer per clock on both sides:
// a pixel is taken into an input register, and its result moves on into the output register
// when that register is free or its result is being taken. While a result waits for the
// sink, the input register can still take one more pixel; after that the input is held off
// until the sink takes the result, since the sink's ready passes straight through to the
// input's ready. The one multiplier (destination row times width) sits between those two
// registers.
// Configuration registers are written through a simple write port and should be changed
// only while no pixel is in flight; the counters keep their position across such writes.
module masked_pixel_to_rgba_converter_core (
	input logic clk,
	input logic arst_n,
	mprc_in_if.sink pixel,
	mprc_out_if.source result,
	input logic cfg_we,
	input logic [mprc_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mprc_pkg::PIX_W-1:0] cfg_data
);
	import mprc_pkg::*;

	// Configuration registers, with each mask's shift kept next to it.
	logic [PIX_W-1:0] mask_q [NUM_CHAN];
	chan_shift_t shift_q [NUM_CHAN];
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic flip_v_q;
	logic flip_h_q;

	// Position of the next pixel to be taken.
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	// Input register stage.
	logic valid_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [IDX_W-1:0] drow_s1;
	logic [IDX_W-1:0] dcol_s1;
	logic last_s1;

	// Output register stage.
	logic valid_s2;
	logic [PIX_W-1:0] rgba_s2;
	logic [IDX_W-1:0] idx_s2;
	logic last_s2;

	logic accept;
	logic s1_ready;
	logic s2_ready;
	logic [DIM_W-1:0] col_next;
	logic [DIM_W-1:0] row_next;
	logic row_end;
	logic img_end;
	logic [IDX_W-1:0] drow;
	logic [IDX_W-1:0] dcol;
	logic [CHAN_W-1:0] chan_val [NUM_CHAN];
	logic [PIX_W-1:0] rgba;
	logic [IDX_W+DIM_W-1:0] row_base;
	logic [IDX_W-1:0] idx;

	// Configuration writes. Each register keeps only the bits of its own width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q[CH_RED] <= 32'h0000_00FF;
			mask_q[CH_GREEN] <= 32'h0000_FF00;
			mask_q[CH_BLUE] <= 32'h00FF_0000;
			mask_q[CH_ALPHA] <= 32'hFF00_0000;
			shift_q[CH_RED] <= calc_shift(32'h0000_00FF);
			shift_q[CH_GREEN] <= calc_shift(32'h0000_FF00);
			shift_q[CH_BLUE] <= calc_shift(32'h00FF_0000);
			shift_q[CH_ALPHA] <= calc_shift(32'hFF00_0000);
			width_q <= DIM_W'(1);
			height_q <= DIM_W'(1);
			flip_v_q <= 1'b0;
			flip_h_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_RED_MASK: begin
					mask_q[CH_RED] <= cfg_data;
					shift_q[CH_RED] <= calc_shift(cfg_data);
				end
				REG_GREEN_MASK: begin
					mask_q[CH_GREEN] <= cfg_data;
					shift_q[CH_GREEN] <= calc_shift(cfg_data);
				end
				REG_BLUE_MASK: begin
					mask_q[CH_BLUE] <= cfg_data;
					shift_q[CH_BLUE] <= calc_shift(cfg_data);
				end
				REG_ALPHA_MASK: begin
					mask_q[CH_ALPHA] <= cfg_data;
					shift_q[CH_ALPHA] <= calc_shift(cfg_data);
				end
				REG_IMAGE_WIDTH: begin
					width_q <= eff_dim(cfg_data[DIM_W-1:0]);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= eff_dim(cfg_data[DIM_W-1:0]);
				end
				REG_FLIP_VERTICAL: begin
					flip_v_q <= cfg_data[0];
				end
				REG_FLIP_HORIZONTAL: begin
					flip_h_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// Flow control: each stage moves when the stage after it is free or draining.
	assign s2_ready = !valid_s2 || result.ready;
	assign s1_ready = !valid_s1 || s2_ready;
	assign pixel.ready = s1_ready;
	assign accept = pixel.valid && s1_ready;

	// A counter at or beyond the bound counts as the last of its row or column.
	assign col_next = {1'b0, col_q} + DIM_W'(1);
	assign row_next = {1'b0, row_q} + DIM_W'(1);
	assign row_end = col_next >= width_q;
	assign img_end = row_end && (row_next >= height_q);

	// Flipped positions wrap modulo the index width when a counter is past the bound.
	always_comb begin
		if (flip_v_q) begin
			drow = IDX_W'(height_q) - IDX_W'(1) - IDX_W'(row_q);
		end else begin
			drow = IDX_W'(row_q);
		end
		if (flip_h_q) begin
			dcol = IDX_W'(width_q) - IDX_W'(1) - IDX_W'(col_q);
		end else begin
			dcol = IDX_W'(col_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_next[CNT_W-1:0];
			end else begin
				col_q <= col_next[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= pixel.source_pixel;
			drow_s1 <= drow;
			dcol_s1 <= dcol;
			last_s1 <= img_end;
		end
	end

	// Channel placement, one unit per channel.
	for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
		mprc_chan_place u_place (
			.pixel(pix_s1),
			.mask(mask_q[c]),
			.shift(shift_q[c]),
			.value(chan_val[c])
		);
	end

	// An empty alpha mask means a fully opaque pixel.
	always_comb begin
		rgba[CHAN_W*CH_RED +: CHAN_W] = chan_val[CH_RED];
		rgba[CHAN_W*CH_GREEN +: CHAN_W] = chan_val[CH_GREEN];
		rgba[CHAN_W*CH_BLUE +: CHAN_W] = chan_val[CH_BLUE];
		if (mask_q[CH_ALPHA] == '0) begin
			rgba[CHAN_W*CH_ALPHA +: CHAN_W] = '1;
		end else begin
			rgba[CHAN_W*CH_ALPHA +: CHAN_W] = chan_val[CH_ALPHA];
		end
	end

	assign row_base = (IDX_W+DIM_W)'(drow_s1) * (IDX_W+DIM_W)'(width_q);
	assign idx = row_base[IDX_W-1:0] + dcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			rgba_s2 <= rgba;
			idx_s2 <= idx;
			last_s2 <= last_s1;
		end
	end

	assign result.valid = valid_s2;
	assign result.rgba_word = rgba_s2;
	assign result.dest_index = idx_s2;
	assign result.last_pixel = last_s2;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the masked pixel to RGBA8888 converter core.
module tb_top;

	import mprc_pkg::*;

	// Each idling profile runs about this many random pixels.
	localparam int unsigned ITEMS_PER_PHASE = 480;
	// The run is abandoned after this many cycles with no transfer on either channel.
	localparam int unsigned STALL_LIMIT = 5000;
	// Mismatch lines beyond this count are tallied but no longer printed.
	localparam int unsigned MAX_REPORTS = 100;

	// One converted pixel as it should leave the block.
	typedef struct packed {
		logic [PIX_W-1:0] rgba;
		logic [IDX_W-1:0] dest_idx;
		logic is_last;
	} converted_pixel_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0] cfg_data;

	mprc_in_if pixel_ch();
	mprc_out_if result_ch();

	masked_pixel_to_rgba_converter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Source pixels waiting for the driver, and conversions waiting for the block to emit them.
	logic [PIX_W-1:0] pending_pixels [$];
	converted_pixel_t expected_pixels [$];

	// The testbench's own copy of the configuration registers and the image position.
	logic [PIX_W-1:0] chan_mask [NUM_CHAN];
	logic [DIM_W-1:0] width_reg;
	logic [DIM_W-1:0] height_reg;
	logic flip_v;
	logic flip_h;
	logic [CNT_W-1:0] col_pos;
	logic [CNT_W-1:0] row_pos;

	// Chance, in percent, that the sender or the receiver sits out a given cycle.
	int unsigned src_idle_pct;
	int unsigned snk_idle_pct;

	int unsigned error_count = 0;
	int unsigned pixels_checked = 0;
	int unsigned frames_done = 0;
	int unsigned reg_writes = 0;

	task automatic report_mismatch(input string what);
		error_count++;
		if (error_count <= MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s", $time, what);
		end
	endtask

	// A dimension register of zero behaves as one, and anything past the maximum as the maximum.
	function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] raw);
		if (raw == '0) begin
			return 32'd1;
		end
		if (raw > DIM_W'(MAX_DIM)) begin
			return 32'(MAX_DIM);
		end
		return 32'(raw);
	endfunction

	// Moves the masked source bits so that the highest mask bit ends up on bit 7.
	// Bits that fall below the byte are lost, and nothing is replicated into the low bits.
	function automatic logic [CHAN_W-1:0] place_bits(input logic [PIX_W-1:0] pix,
		input logic [PIX_W-1:0] mask);
		int top;
		logic [PIX_W-1:0] v;
		top = 0;
		for (int i = 0; i < PIX_W; i++) begin
			if (mask[i]) begin
				top = i;
			end
		end
		v = pix & mask;
		if (top >= CHAN_W - 1) begin
			v = v >> (top - (CHAN_W - 1));
		end else begin
			v = v << ((CHAN_W - 1) - top);
		end
		return v[CHAN_W-1:0];
	endfunction

	// Works out the conversion of one accepted pixel, queues it, and steps the image position.
	task automatic predict_pixel(input logic [PIX_W-1:0] pix);
		converted_pixel_t conv;
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] drow;
		logic [31:0] dcol;
		logic [31:0] flat;
		logic row_end;
		conv.rgba = '0;
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (chan_mask[c] != '0) begin
				conv.rgba[CHAN_W*c +: CHAN_W] = place_bits(pix, chan_mask[c]);
			end else if (c == CH_ALPHA) begin
				// With no alpha bits in the source the pixel is fully opaque.
				conv.rgba[CHAN_W*c +: CHAN_W] = '1;
			end
		end
		w = clamp_dim(width_reg);
		h = clamp_dim(height_reg);
		x = 32'(col_pos);
		y = 32'(row_pos);
		// A counter left beyond a shrunken bound wraps here, exactly as 32-bit unsigned math does.
		drow = flip_v ? (h - 32'd1 - y) : y;
		dcol = flip_h ? (w - 32'd1 - x) : x;
		flat = drow * w + dcol;
		conv.dest_idx = flat[IDX_W-1:0];
		row_end = (x + 32'd1 >= w);
		conv.is_last = row_end && (y + 32'd1 >= h);
		expected_pixels.push_back(conv);
		if (row_end) begin
			col_pos = '0;
			row_pos = conv.is_last ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endtask

	// Writes one register through the configuration port and mirrors it in the local copy.
	// The enable is raised in step with the clock and dropped again once the register has taken the write.
	task automatic write_reg(input reg_idx_t r, input logic [PIX_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (r)
			REG_RED_MASK: chan_mask[CH_RED] = data;
			REG_GREEN_MASK: chan_mask[CH_GREEN] = data;
			REG_BLUE_MASK: chan_mask[CH_BLUE] = data;
			REG_ALPHA_MASK: chan_mask[CH_ALPHA] = data;
			REG_IMAGE_WIDTH: width_reg = data[DIM_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = data[DIM_W-1:0];
			REG_FLIP_VERTICAL: flip_v = data[0];
			REG_FLIP_HORIZONTAL: flip_h = data[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Blocks until the driver has nothing left and every queued conversion has come out.
	// Sampling on the falling edge keeps this clear of the updates made at the rising edge.
	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_pixels.size() != 0 || pixel_ch.valid || expected_pixels.size() != 0);
	endtask

	// Masks are mostly contiguous fields such as real pixel formats use, plus empty, full and
	// scattered ones.
	function automatic logic [PIX_W-1:0] pick_mask();
		int unsigned len;
		int unsigned pos;
		logic [PIX_W:0] field;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom();
			default: begin
				len = $urandom_range(1, 12);
				pos = $urandom_range(0, PIX_W - len);
				field = ((33'd1 << len) - 33'd1) << pos;
				return field[PIX_W-1:0];
			end
		endcase
	endfunction

	// Dimensions are mostly small so that whole images go by; zero, the maximum and values past
	// it appear now and then, sometimes with junk above the register's width.
	function automatic logic [PIX_W-1:0] pick_dim();
		logic [DIM_W-1:0] d;
		logic [PIX_W-DIM_W-1:0] upper;
		case ($urandom_range(19))
			0: d = '0;
			1: d = DIM_W'(MAX_DIM);
			2: d = DIM_W'($urandom_range(MAX_DIM + 1, 8191));
			3, 4: d = DIM_W'($urandom_range(9, 64));
			default: d = DIM_W'($urandom_range(1, 8));
		endcase
		upper = ($urandom_range(3) == 0) ? (PIX_W-DIM_W)'($urandom()) : '0;
		return {upper, d};
	endfunction

	// Pixels are 1 to 4 bytes wide with the unused upper bytes zero, plus all-zero and all-one.
	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] pix;
		int unsigned nbytes;
		pix = $urandom();
		nbytes = $urandom_range(1, 4);
		case ($urandom_range(15))
			0: pix = '0;
			1: pix = '1;
			default: begin
				if (nbytes < 4) begin
					pix = pix & ((32'd1 << (8 * nbytes)) - 32'd1);
				end
			end
		endcase
		return pix;
	endfunction

	// Rewrites either every register or a random subset of them.
	task automatic program_random(input bit all_regs);
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_RED_MASK, pick_mask());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_GREEN_MASK, pick_mask());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_BLUE_MASK, pick_mask());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_ALPHA_MASK, pick_mask());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_IMAGE_WIDTH, pick_dim());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_IMAGE_HEIGHT, pick_dim());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_FLIP_VERTICAL, $urandom());
		if (all_regs || $urandom_range(2) == 0) write_reg(REG_FLIP_HORIZONTAL, $urandom());
	endtask

	// Driver. The source holds a pixel until it is taken, and only then may pause or move on.
	// The receiver's ready is drawn fresh every cycle from the current idling profile.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (pending_pixels.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					pixel_ch.valid <= 1'b1;
					pixel_ch.source_pixel <= pending_pixels.pop_front();
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
			result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// Monitor. Every input transfer gets its conversion predicted at once; every output transfer
	// is held against the oldest prediction still waiting. The prediction is pushed first so a
	// block with less latency than expected is still judged fairly.
	always @(posedge clk) begin : result_monitor
		converted_pixel_t want;
		if (arst_n) begin
			if (pixel_ch.valid && pixel_ch.ready) begin
				predict_pixel(pixel_ch.source_pixel);
			end
			if (result_ch.valid && result_ch.ready) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: rgba %h index %0d last %b",
						result_ch.rgba_word, result_ch.dest_index, result_ch.last_pixel));
				end else begin
					want = expected_pixels.pop_front();
					if (result_ch.rgba_word !== want.rgba) begin
						report_mismatch($sformatf("rgba_word %h, expected %h",
							result_ch.rgba_word, want.rgba));
					end
					if (result_ch.dest_index !== want.dest_idx) begin
						report_mismatch($sformatf("dest_index %0d, expected %0d",
							result_ch.dest_index, want.dest_idx));
					end
					if (result_ch.last_pixel !== want.is_last) begin
						report_mismatch($sformatf("last_pixel %b, expected %b",
							result_ch.last_pixel, want.is_last));
					end
					pixels_checked++;
					if (want.is_last) begin
						frames_done++;
					end
				end
			end
		end
	end

	// Watchdog: a long stretch with no transfer on either channel means the block has hung.
	initial begin : stall_watchdog
		int unsigned quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Watchdog: no transfer for %0d cycles, %0d conversions still outstanding",
			STALL_LIMIT, expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase;
		int unsigned sent;
		int unsigned len;
		logic [31:0] img;

		// Every input is known from time zero; the registers start at their reset values.
		pixel_ch.valid = 1'b0;
		pixel_ch.source_pixel = '0;
		result_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_RED_MASK;
		cfg_data = '0;
		chan_mask[CH_RED] = 32'h0000_00FF;
		chan_mask[CH_GREEN] = 32'h0000_FF00;
		chan_mask[CH_BLUE] = 32'h00FF_0000;
		chan_mask[CH_ALPHA] = 32'hFF00_0000;
		width_reg = DIM_W'(1);
		height_reg = DIM_W'(1);
		flip_v = 1'b0;
		flip_h = 1'b0;
		col_pos = '0;
		row_pos = '0;
		src_idle_pct = 12;
		snk_idle_pct = 76;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a one-pixel image in the default byte layout, so every pixel ends a frame.
		@(negedge clk);
		pending_pixels.push_back(32'h0000_0000);
		pending_pixels.push_back(32'hFFFF_FFFF);
		pending_pixels.push_back(32'h1234_5678);
		wait_drained();

		// A 16-bit 5-6-5 layout with no alpha bits, which must read as opaque. The 3 by 2 image
		// with both flips on runs through one full frame, covering row ends and the frame end.
		write_reg(REG_RED_MASK, 32'h0000_F800);
		write_reg(REG_GREEN_MASK, 32'h0000_07E0);
		write_reg(REG_BLUE_MASK, 32'h0000_001F);
		write_reg(REG_ALPHA_MASK, 32'h0000_0000);
		write_reg(REG_IMAGE_WIDTH, 32'd3);
		write_reg(REG_IMAGE_HEIGHT, 32'd2);
		write_reg(REG_FLIP_VERTICAL, 32'd1);
		write_reg(REG_FLIP_HORIZONTAL, 32'd1);
		@(negedge clk);
		pending_pixels.push_back(32'h0000_FFFF);
		pending_pixels.push_back(32'h0000_0000);
		pending_pixels.push_back(32'h0000_F800);
		pending_pixels.push_back(32'h0000_07E0);
		pending_pixels.push_back(32'h0000_001F);
		pending_pixels.push_back(32'h0000_A5A5);
		wait_drained();

		// Unflipped, stopping mid-way through the second row of the next frame.
		write_reg(REG_FLIP_VERTICAL, 32'd0);
		write_reg(REG_FLIP_HORIZONTAL, 32'd0);
		@(negedge clk);
		pending_pixels.push_back(32'h0000_8001);
		pending_pixels.push_back(32'h0000_7FFE);
		pending_pixels.push_back(32'h0000_0F0F);
		pending_pixels.push_back(32'h0000_F0F0);
		wait_drained();

		// The width changes mid-frame to a value whose low 13 bits are zero: only those bits
		// count, zero acts as one, and the column counter already sits past the new bound.
		write_reg(REG_IMAGE_WIDTH, 32'hFFFF_E000);
		@(negedge clk);
		pending_pixels.push_back(32'h0000_00C3);
		pending_pixels.push_back(32'h0000_3C00);
		wait_drained();

		// Masks with their top bit at bit 0, bit 1 and bit 31; the full mask drops its low bits.
		// Both dimensions go past the maximum and clamp to it, and with both flips the first
		// pixel lands in the last column of the next-to-last row.
		write_reg(REG_RED_MASK, 32'h0000_0001);
		write_reg(REG_GREEN_MASK, 32'h8000_0000);
		write_reg(REG_BLUE_MASK, 32'hFFFF_FFFF);
		write_reg(REG_ALPHA_MASK, 32'h0000_0003);
		write_reg(REG_IMAGE_WIDTH, 32'h0000_1005);
		write_reg(REG_IMAGE_HEIGHT, 32'h0000_1FFF);
		write_reg(REG_FLIP_VERTICAL, 32'd1);
		write_reg(REG_FLIP_HORIZONTAL, 32'd1);
		@(negedge clk);
		pending_pixels.push_back(32'hFFFF_FFFF);
		pending_pixels.push_back(32'h0000_0000);
		pending_pixels.push_back(32'h8000_0001);
		pending_pixels.push_back(32'h7FFF_FFFE);
		pending_pixels.push_back(32'h0000_0002);

		// Random part, once per idling profile: a slow receiver, then a slow sender, then neither.
		for (phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					src_idle_pct = 12;
					snk_idle_pct = 76;
				end
				1: begin
					src_idle_pct = 76;
					snk_idle_pct = 12;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			program_random(1'b1);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				// Between bursts the sender may stop until the block has emptied, sometimes to
				// change settings; otherwise the next burst follows straight on.
				case ($urandom_range(3))
					0: begin
						wait_drained();
						program_random(1'b0);
					end
					1: wait_drained();
					default: ;
				endcase
				// Small images are sent as exact frames half the time so frame ends come regularly.
				img = clamp_dim(width_reg) * clamp_dim(height_reg);
				if (img <= 32'd64 && $urandom_range(1) == 1) begin
					len = img;
				end else begin
					len = $urandom_range(1, 40);
				end
				@(negedge clk);
				repeat (len) pending_pixels.push_back(pick_pixel());
				sent += len;
			end
		end

		// Let everything come out, then keep the clock running with nothing sent to catch any stray result.
		wait_drained();
		repeat (8) @(posedge clk);
		$display("Run covered %0d converted pixels and %0d frame ends across %0d register writes,",
			pixels_checked, frames_done, reg_writes);
		$display("under three idling profiles; %0d mismatches found.", error_count);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
